>>> design/wcpu_pkg.sv
// ----------------------------------------------------------------------------
// wcpu_pkg
// Shared constants, types and instruction field helpers for the word CPU
// execute step.
// ----------------------------------------------------------------------------
package wcpu_pkg;

  localparam int MEM_ADDR_BITS = 10;
  localparam int MEM_WORDS     = 1 << MEM_ADDR_BITS;
  localparam int RET_DEPTH     = 16;
  localparam int RS_IDX_W      = $clog2(RET_DEPTH);
  localparam int RS_CNT_W      = $clog2(RET_DEPTH + 1);
  localparam int WORD_W        = 32;
  localparam int REG_IDX_W     = 5;
  localparam int NUM_REGS      = 1 << REG_IDX_W;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // register that comes out of reset holding the data memory size
  localparam reg_idx_t MEM_SIZE_REG = 5'd7;

  typedef enum logic [4:0] {
    OP_RET    = 5'h00,
    OP_ADD    = 5'h01,
    OP_SUB    = 5'h02,
    OP_MUL    = 5'h03,
    OP_XOR    = 5'h04,
    OP_AND    = 5'h05,
    OP_OR     = 5'h06,
    OP_LT     = 5'h07,
    OP_GT     = 5'h08,
    OP_EQ     = 5'h09,
    OP_JUMP   = 5'h0a,
    OP_BNEQZ  = 5'h0b,
    OP_INPUT  = 5'h0c,
    OP_OUTPUT = 5'h0d,
    OP_LOAD   = 5'h0e,
    OP_STORE  = 5'h0f,
    OP_CALL   = 5'h10,
    OP_COPY   = 5'h11,
    OP_NEQ    = 5'h12
  } opcode_t;

  // one register file write, issued from the writeback stage
  typedef struct packed {
    logic     en;
    reg_idx_t addr;
    word_t    data;
  } rf_wr_t;

  // register selects of one instruction
  typedef struct packed {
    reg_idx_t a;
    reg_idx_t b;
    reg_idx_t t;
  } rf_sel_t;

  function automatic logic instr_imm(input word_t w);
    return w[31];
  endfunction

  function automatic opcode_t instr_op(input word_t w);
    return opcode_t'(w[30:26]);
  endfunction

  function automatic rf_sel_t instr_sel(input word_t w);
    rf_sel_t s;
    s.t = w[25:21];
    s.a = w[20:16];
    s.b = w[15:11];
    return s;
  endfunction

  function automatic word_t instr_simm(input word_t w);
    return {{16{w[15]}}, w[15:0]};
  endfunction

  function automatic word_t rf_reset_val(input reg_idx_t idx);
    return (idx == MEM_SIZE_REG) ? WORD_W'(MEM_WORDS) : '0;
  endfunction

endpackage

>>> design/word_cpu_execute_step_core.sv
// ----------------------------------------------------------------------------
// word_cpu_execute_step_core
// Executes one 32-bit instruction word per input beat and returns one
// result beat with next pc, output word and status flags.
// ----------------------------------------------------------------------------
//
//  Channel | Payload ports                                  | Beat taken on
//  --------+------------------------------------------------+----------------------
//  in      | in_instr_word, in_data                         | in_valid & in_ready
//  out     | out_next_pc, out_out_valid, out_data,          | out_valid & out_ready
//          | out_in_taken, out_halted, out_stack_overflow   |
//
//  Throughput is one instruction per cycle while results drain; operands
//  are read on the input beat's edge and the result register loads when
//  execute fires. After reset the data memory is zeroed by a sweep over all
//  2^MEM_ADDR_BITS words (1024), during which in_ready stays low.
//  Register writes retire in the cycle after execute; a load's result comes
//  from the memory read register and is forwarded, so no bubble follows it.
//  A stalled result holds the execute stage; a beat can still fill it when empty.
//
module word_cpu_execute_step_core import wcpu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instr_word,
  input  logic [31:0] in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_next_pc,
  output logic        out_out_valid,
  output logic [31:0] out_data,
  output logic        out_in_taken,
  output logic        out_halted,
  output logic        out_stack_overflow
);

  // memory clear sweep
  logic                     clr_busy_r;
  logic [MEM_ADDR_BITS-1:0] clr_addr_r;

  // execute stage (input register)
  logic  s1_v_r;
  word_t s1_instr_r;
  word_t s1_din_r;

  // architectural state
  word_t               pc_r;
  logic                halt_r;
  logic [RS_CNT_W-1:0] rs_depth_r;
  word_t               rs_mem_r [RET_DEPTH];
  word_t               dmem [MEM_WORDS];
  word_t               mem_rd_r;

  // writeback stage
  logic     wb_en_r;
  reg_idx_t wb_addr_r;
  word_t    wb_alu_r;
  logic     wb_ld_r;

  // result register
  logic  out_v_r;
  word_t o_pc_r;
  logic  o_oval_r;
  word_t o_odata_r;
  logic  o_taken_r;
  logic  o_halt_r;
  logic  o_ovf_r;

  logic    s1_fire;
  logic    in_fire;
  rf_sel_t s1_sel;
  rf_wr_t  rf_wr;
  word_t   rf_a;
  word_t   rf_b;
  word_t   rf_t;

  // execute results
  word_t                    s_val;
  word_t                    addr_sum;
  logic [MEM_ADDR_BITS-1:0] mem_addr;
  word_t                    pc_inc;
  logic [RS_CNT_W-1:0]      rs_dec;
  logic                     rs_full;
  word_t                    ex_pc;
  logic                     ex_halt;
  logic                     ex_wr;
  word_t                    ex_wdata;
  logic                     ex_ld;
  logic                     ex_st;
  logic                     ex_push;
  logic                     ex_pop;
  logic                     ex_ovf;
  logic                     ex_oval;
  word_t                    ex_odata;
  logic                     ex_taken;

  // --------------------------------------------------------------------------
  // Handshake: execute advances when the result register is free or drains
  // --------------------------------------------------------------------------
  assign s1_fire  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !clr_busy_r && (!s1_v_r || s1_fire);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr_r <= in_instr_word;
      s1_din_r   <= in_data;
    end
  end

  assign s1_sel = instr_sel(s1_instr_r);

  // --------------------------------------------------------------------------
  // Register file: operands read on the input beat, pending write forwarded
  // --------------------------------------------------------------------------
  assign rf_wr.en   = wb_en_r;
  assign rf_wr.addr = wb_addr_r;
  assign rf_wr.data = wb_ld_r ? mem_rd_r : wb_alu_r;

  wcpu_regfile u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_fire),
    .rd_sel (instr_sel(in_instr_word)),
    .wr     (rf_wr),
    .a_val  (rf_a),
    .b_val  (rf_b),
    .t_val  (rf_t)
  );

  // --------------------------------------------------------------------------
  // Execute
  // --------------------------------------------------------------------------
  assign s_val    = instr_imm(s1_instr_r) ? instr_simm(s1_instr_r) : rf_b;
  assign addr_sum = rf_a + s_val;
  assign mem_addr = addr_sum[MEM_ADDR_BITS-1:0];
  assign pc_inc   = pc_r + 32'd1;
  assign rs_dec   = rs_depth_r - 1'b1;
  assign rs_full  = (rs_depth_r == RS_CNT_W'(RET_DEPTH));

  always_comb begin
    ex_pc    = pc_r;
    ex_halt  = halt_r;
    ex_wr    = 1'b0;
    ex_wdata = '0;
    ex_ld    = 1'b0;
    ex_st    = 1'b0;
    ex_push  = 1'b0;
    ex_pop   = 1'b0;
    ex_ovf   = 1'b0;
    ex_oval  = 1'b0;
    ex_odata = '0;
    ex_taken = 1'b0;
    if (!halt_r) begin
      unique case (instr_op(s1_instr_r))
        OP_RET: begin
          // empty stack stops the machine and keeps pc
          if (rs_depth_r == '0) begin
            ex_halt = 1'b1;
          end else begin
            ex_pop = 1'b1;
            ex_pc  = rs_mem_r[rs_dec[RS_IDX_W-1:0]];
          end
        end
        OP_ADD: begin
          ex_wr = 1'b1; ex_wdata = rf_a + s_val; ex_pc = pc_inc;
        end
        OP_SUB: begin
          ex_wr = 1'b1; ex_wdata = rf_a - s_val; ex_pc = pc_inc;
        end
        OP_MUL: begin
          ex_wr = 1'b1; ex_wdata = rf_a * s_val; ex_pc = pc_inc;
        end
        OP_XOR: begin
          ex_wr = 1'b1; ex_wdata = rf_a ^ s_val; ex_pc = pc_inc;
        end
        OP_AND: begin
          ex_wr = 1'b1; ex_wdata = rf_a & s_val; ex_pc = pc_inc;
        end
        OP_OR: begin
          ex_wr = 1'b1; ex_wdata = rf_a | s_val; ex_pc = pc_inc;
        end
        OP_LT: begin
          ex_wr = 1'b1; ex_wdata = {31'd0, rf_a < s_val}; ex_pc = pc_inc;
        end
        OP_GT: begin
          ex_wr = 1'b1; ex_wdata = {31'd0, rf_a > s_val}; ex_pc = pc_inc;
        end
        OP_EQ: begin
          ex_wr = 1'b1; ex_wdata = {31'd0, rf_a == s_val}; ex_pc = pc_inc;
        end
        OP_NEQ: begin
          ex_wr = 1'b1; ex_wdata = {31'd0, rf_a != s_val}; ex_pc = pc_inc;
        end
        OP_JUMP: begin
          ex_pc = s_val;
        end
        OP_BNEQZ: begin
          ex_pc = (rf_a == '0) ? pc_inc : s_val;
        end
        OP_INPUT: begin
          ex_wr = 1'b1; ex_wdata = s1_din_r; ex_taken = 1'b1; ex_pc = pc_inc;
        end
        OP_OUTPUT: begin
          ex_oval = 1'b1; ex_odata = rf_t; ex_pc = pc_inc;
        end
        OP_LOAD: begin
          ex_wr = 1'b1; ex_ld = 1'b1; ex_pc = pc_inc;
        end
        OP_STORE: begin
          ex_st = 1'b1; ex_pc = pc_inc;
        end
        OP_CALL: begin
          // full stack: flag it, drop the push, still jump
          if (rs_full) begin
            ex_ovf = 1'b1;
          end else begin
            ex_push = 1'b1;
          end
          ex_pc = s_val;
        end
        OP_COPY: begin
          ex_wr = 1'b1; ex_wdata = s_val; ex_pc = pc_inc;
        end
        default: begin
          // unknown opcode: leave all state alone
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Architectural state update
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r       <= '0;
      halt_r     <= 1'b0;
      rs_depth_r <= '0;
    end else if (s1_fire) begin
      pc_r   <= ex_pc;
      halt_r <= ex_halt;
      if (ex_push) begin
        rs_depth_r <= rs_depth_r + 1'b1;
      end else if (ex_pop) begin
        rs_depth_r <= rs_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && ex_push) begin
      rs_mem_r[rs_depth_r[RS_IDX_W-1:0]] <= pc_inc;
    end
  end

  // data memory: clear sweep after reset, then one store or load per cycle when execute fires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      dmem[clr_addr_r] <= '0;
    end else if (s1_fire && ex_st) begin
      dmem[mem_addr] <= rf_t;
    end
    if (s1_fire && ex_ld) begin
      mem_rd_r <= dmem[mem_addr];
    end
  end

  // writeback: in the cycle after execute, load data picked from mem_rd_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_en_r <= 1'b0;
    end else begin
      wb_en_r <= s1_fire && ex_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      wb_addr_r <= s1_sel.t;
      wb_alu_r  <= ex_wdata;
      wb_ld_r   <= ex_ld;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      o_pc_r    <= ex_pc;
      o_oval_r  <= ex_oval;
      o_odata_r <= ex_odata;
      o_taken_r <= ex_taken;
      o_halt_r  <= ex_halt;
      o_ovf_r   <= ex_ovf;
    end
  end

  assign out_valid          = out_v_r;
  assign out_next_pc        = o_pc_r;
  assign out_out_valid      = o_oval_r;
  assign out_data           = o_odata_r;
  assign out_in_taken       = o_taken_r;
  assign out_halted         = o_halt_r;
  assign out_stack_overflow = o_ovf_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared after halt");

  a_halted_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && halt_r) |=> !wb_en_r)
    else $error("register write issued while halted");

  a_ovf_keeps_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && ex_ovf) |=> (rs_depth_r == RS_CNT_W'(RET_DEPTH)))
    else $error("overflowing call changed the return stack depth");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rs_depth_r <= RS_CNT_W'(RET_DEPTH))
    else $error("return stack depth out of range");

endmodule

>>> design/wcpu_regfile.sv
// ----------------------------------------------------------------------------
// wcpu_regfile
// Three-bank register file with registered operand reads, reset-value
// masking by valid bits, and forwarding of the pending writeback.
// ----------------------------------------------------------------------------
module wcpu_regfile import wcpu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    rd_en,
  input  rf_sel_t rd_sel,
  input  rf_wr_t  wr,
  output word_t   a_val,
  output word_t   b_val,
  output word_t   t_val
);

  word_t bank_a [NUM_REGS];
  word_t bank_b [NUM_REGS];
  word_t bank_t [NUM_REGS];

  logic [NUM_REGS-1:0] vld_r;
  rf_sel_t             sel_r;
  word_t               a_q_r;
  word_t               b_q_r;
  word_t               t_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sel_r <= rd_sel;
    end
  end

  // each bank: one write port, one registered read port; the operand
  // register also snoops writes while its instruction waits
  always_ff @(posedge clk) begin
    if (wr.en) begin
      bank_a[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      if (wr.en && wr.addr == rd_sel.a) begin
        a_q_r <= wr.data;
      end else if (!vld_r[rd_sel.a]) begin
        a_q_r <= rf_reset_val(rd_sel.a);
      end else begin
        a_q_r <= bank_a[rd_sel.a];
      end
    end else if (wr.en && wr.addr == sel_r.a) begin
      a_q_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      bank_b[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      if (wr.en && wr.addr == rd_sel.b) begin
        b_q_r <= wr.data;
      end else if (!vld_r[rd_sel.b]) begin
        b_q_r <= rf_reset_val(rd_sel.b);
      end else begin
        b_q_r <= bank_b[rd_sel.b];
      end
    end else if (wr.en && wr.addr == sel_r.b) begin
      b_q_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      bank_t[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      if (wr.en && wr.addr == rd_sel.t) begin
        t_q_r <= wr.data;
      end else if (!vld_r[rd_sel.t]) begin
        t_q_r <= rf_reset_val(rd_sel.t);
      end else begin
        t_q_r <= bank_t[rd_sel.t];
      end
    end else if (wr.en && wr.addr == sel_r.t) begin
      t_q_r <= wr.data;
    end
  end

  // forward the write that lands at the coming edge
  assign a_val = (wr.en && wr.addr == sel_r.a) ? wr.data : a_q_r;
  assign b_val = (wr.en && wr.addr == sel_r.b) ? wr.data : b_q_r;
  assign t_val = (wr.en && wr.addr == sel_r.t) ? wr.data : t_q_r;

endmodule
